// ----- rtl/xcfd_pkg.sv -----
// shared types and constants for the xor checksum frame decoder
`default_nettype none
package xcfd_pkg;

   localparam logic [7:0]  SOF_BYTE         = 8'hFE;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd128;

   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_GOOD     = 2'd1;
   localparam logic [1:0] KIND_BAD      = 2'd2;
   localparam logic [1:0] KIND_TOO_LONG = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [1:0]  result_kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] function_code;
      logic [15:0] payload_length;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/xcfd_parser.sv -----
// frame phase tracker, running xor and result generation
`default_nettype none
module xcfd_parser import xcfd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [15:0] max_length,
   output result_type       res
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_FUNC_HI = 3'd1;
   localparam logic [2:0] PH_FUNC_LO = 3'd2;
   localparam logic [2:0] PH_LEN_HI  = 3'd3;
   localparam logic [2:0] PH_LEN_LO  = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_CHECK   = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] function_ff, function_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] count_next;

   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      function_in = function_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      res         = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SOF_BYTE) begin
               xor_in   = SOF_BYTE;
               phase_in = PH_FUNC_HI;
            end
         end
         PH_FUNC_HI: begin
            function_in = {rx_byte, 8'd0};
            xor_in      = xor_ff ^ rx_byte;
            phase_in    = PH_FUNC_LO;
         end
         PH_FUNC_LO: begin
            function_in = {function_ff[15:8], rx_byte};
            xor_in      = xor_ff ^ rx_byte;
            phase_in    = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {rx_byte, 8'd0};
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {length_ff[15:8], rx_byte};
            xor_in    = xor_ff ^ rx_byte;
            count_in  = '0;
            if (length_in > max_length) begin
               phase_in        = PH_HUNT;
               res.valid       = 1'b1;
               res.result_kind = KIND_TOO_LONG;
            end else if (length_in == 16'd0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            xor_in          = xor_ff ^ rx_byte;
            count_in        = count_next;
            if (count_next >= length_ff) begin
               phase_in = PH_CHECK;
            end
            res.valid       = 1'b1;
            res.result_kind = KIND_DATA;
            res.data_byte   = rx_byte;
            res.byte_index  = count_ff;
         end
         PH_CHECK: begin
            phase_in        = PH_HUNT;
            res.valid       = 1'b1;
            res.result_kind = (rx_byte == xor_ff) ? KIND_GOOD : KIND_BAD;
            res.data_byte   = rx_byte;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      res.function_code  = function_in;
      res.payload_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         function_ff <= '0;
         length_ff   <= '0;
         count_ff    <= '0;
         xor_ff      <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         function_ff <= function_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         xor_ff      <= xor_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/xcfd_out_reg.sv -----
// result register with valid and ready towards the consumer
`default_nettype none
module xcfd_out_reg import xcfd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  res,
   output logic             in_ready,
   output logic             out_valid,
   input  wire logic        out_ready,
   output result_type       out_res
);

   logic       valid_ff;
   result_type res_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;

   always_comb begin
      out_res       = res_ff;
      out_res.valid = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && res.valid) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         res_ff <= res;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/xor_checksum_frame_decoder.sv -----
// top level of the xor checksum frame decoder
// a word that causes a result is registered and shows it on rsp_ in the cycle after acceptance
// throughput: one word per cycle; req_ready drops only while a result waits on rsp_ready
// words dropped while hunting give no result; header words give none, but for a too long length
// reset: synchronous, active high; hunting for the start byte, max_length back to 128
`default_nettype none
module xor_checksum_frame_decoder import xcfd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_byte_index,
   output logic [15:0]      rsp_function_code,
   output logic [15:0]      rsp_payload_length,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_length
);

   logic [15:0] max_length_ff;
   logic        accept;
   result_type  res;
   result_type  out_res;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         max_length_ff <= csr_max_length;
      end
   end

   xcfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .max_length (max_length_ff),
      .res        (res)
   );

   xcfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res       (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_res   (out_res)
   );

   assign rsp_result_kind    = out_res.result_kind;
   assign rsp_data_byte      = out_res.data_byte;
   assign rsp_byte_index     = out_res.byte_index;
   assign rsp_function_code  = out_res.function_code;
   assign rsp_payload_length = out_res.payload_length;

endmodule
`default_nettype wire
